// ----- rtl/core/grt_pkg.sv -----
// Package for the 2D grid ray traversal core: field types, widths, codes
// and the sequencer's control store. No dependencies.
package grt_pkg;

    localparam int POS_W         = 17;
    localparam int DIR_W         = 16;
    localparam int CELL_W        = 9;
    localparam int POS_FRAC_BITS = 8;
    localparam int DIR_FRAC_BITS = 14;
    localparam int DELTA_FRAC    = 16;
    localparam int DELTA_W       = 32;
    localparam int QUO_W         = DIR_FRAC_BITS + DELTA_FRAC + 1;
    localparam int MAG_W         = DIR_W + 1;
    localparam int DIST_W        = POS_FRAC_BITS + 1;
    localparam int PROD_W        = DIST_W + DELTA_W;
    localparam int SIDE_W        = 47;
    localparam int GRID_MAX      = 512;
    localparam int GRID_W        = 10;
    localparam int MAX_CELLS     = 64;
    localparam int LIM_W         = 7;
    localparam int N_W           = 6;

    typedef logic        [POS_W-1:0]  t_pos;
    typedef logic signed [DIR_W-1:0]  t_dir;
    typedef logic        [CELL_W-1:0] t_cell;
    typedef logic        [1:0]        t_cause;
    typedef logic        [1:0]        t_cfg_idx;
    typedef logic        [GRID_W-1:0] t_cfg_data;

    localparam t_cause CAUSE_LEFT      = 2'd0;
    localparam t_cause CAUSE_LIMIT     = 2'd1;
    localparam t_cause CAUSE_START_OUT = 2'd2;

    localparam t_cfg_idx REG_GRID_W   = 2'd0;
    localparam t_cfg_idx REG_GRID_H   = 2'd1;
    localparam t_cfg_idx REG_STEP_LIM = 2'd2;

    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_CHECK = 2'd1;
    localparam logic [1:0] STEP_SETUP = 2'd2;
    localparam logic [1:0] STEP_WALK  = 2'd3;

    localparam logic [1:0] CND_ALWAYS   = 2'd0;
    localparam logic [1:0] CND_IN_VALID = 2'd1;
    localparam logic [1:0] CND_OUT_FREE = 2'd2;
    localparam logic [1:0] CND_DIV_DONE = 2'd3;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_CHECK = 3'd2;
    localparam logic [2:0] ACT_SETUP = 3'd3;
    localparam logic [2:0] ACT_WALK  = 3'd4;

    typedef struct packed {
        logic [1:0] cond;
        logic [2:0] act;
        logic [1:0] nxt;
        logic [1:0] jmp;
    } t_uword;

    function automatic t_uword uc_rom(input logic [1:0] addr);
        t_uword w;
        unique case (addr)
            STEP_IDLE:  w = '{cond: CND_IN_VALID, act: ACT_LOAD,  nxt: STEP_CHECK, jmp: STEP_CHECK};
            STEP_CHECK: w = '{cond: CND_OUT_FREE, act: ACT_CHECK, nxt: STEP_SETUP, jmp: STEP_IDLE};
            STEP_SETUP: w = '{cond: CND_DIV_DONE, act: ACT_SETUP, nxt: STEP_WALK,  jmp: STEP_WALK};
            STEP_WALK:  w = '{cond: CND_OUT_FREE, act: ACT_WALK,  nxt: STEP_WALK,  jmp: STEP_IDLE};
            default:    w = '{cond: CND_ALWAYS,   act: ACT_NONE,  nxt: STEP_IDLE,  jmp: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/grt_if.sv -----
// Channel interfaces of the grid ray traversal core: ray input, cell output
// and configuration write. Depends on grt_pkg.
interface grt_ray_if;
    logic          valid;
    logic          ready;
    grt_pkg::t_pos pos_x;
    grt_pkg::t_pos pos_y;
    grt_pkg::t_dir dir_x;
    grt_pkg::t_dir dir_y;
    modport source (output valid, pos_x, pos_y, dir_x, dir_y, input ready);
    modport sink   (input valid, pos_x, pos_y, dir_x, dir_y, output ready);
endinterface

interface grt_cell_if;
    logic            valid;
    logic            ready;
    grt_pkg::t_cell  cell_x;
    grt_pkg::t_cell  cell_y;
    logic            hit_side;
    logic            in_grid;
    grt_pkg::t_cause end_cause;
    logic            last;
    modport source (output valid, cell_x, cell_y, hit_side, in_grid, end_cause, last,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, hit_side, in_grid, end_cause, last,
                    output ready);
endinterface

interface grt_cfg_if;
    logic               valid;
    logic               ready;
    grt_pkg::t_cfg_idx  index;
    grt_pkg::t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/grt_recip.sv -----
// Bit-serial restoring divider: delta = 2^(DIR_FRAC_BITS+DELTA_FRAC) / |dir|,
// one quotient bit per cycle, saturated for a zero direction. Depends on grt_pkg.
module grt_recip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  grt_pkg::t_dir              i_dir,
    output logic                       o_done,
    output logic [grt_pkg::DELTA_W-1:0] o_delta
);
    import grt_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_mag;
    logic [MAG_W-2:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;

    logic [MAG_W-1:0]   sx;
    logic [MAG_W-1:0]   n_mag;
    logic [MAG_W-1:0]   trial;
    logic [MAG_W-1:0]   diff;
    logic               ge;

    assign sx    = {i_dir[DIR_W-1], i_dir};
    assign n_mag = sx[MAG_W-1] ? (MAG_W)'(-sx) : sx;
    assign trial = {r_rem, (r_cnt == CNT_W'(QUO_W-1))};
    assign ge    = (trial >= r_mag);
    assign diff  = trial - r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= n_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= CNT_W'(QUO_W-1);
        end else if (r_busy) begin
            r_rem <= ge ? diff[MAG_W-2:0] : trial[MAG_W-2:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done  = r_done;
    assign o_delta = (r_mag == '0) ? '1 : {{(DELTA_W-QUO_W){1'b0}}, r_quo};

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !o_done)
        else $error("divider not busy after start");
    a_busy_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("divider busy and done together");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> o_done)
        else $error("divider did not finish after last bit");
endmodule

// ----- rtl/core/grid_ray_traversal_2d_core.sv -----
// 2D grid ray traversal core: takes one ray per transfer and sends the grid
// cells it visits, in order, one cell per output transfer.
// Depends on grt_pkg, grt_if and grt_recip.
//
// A ray is loaded, then checked; when its start lies outside the grid the check
// sends one out-of-grid cell and ends the ray. Otherwise set-up waits for the
// two bit-serial reciprocal units, which produce one quotient bit per cycle
// (31 bits), then the compare-and-add walk emits one cell per step, up to the
// step limit. A new ray is taken only once the previous one's last cell is
// loaded into the output register. Output stalls hold the check and the walk.
module grid_ray_traversal_2d_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grt_ray_if.sink     i_ray,
    grt_cfg_if.sink     i_cfg,
    grt_cell_if.source  o_cell
);
    import grt_pkg::*;

    logic [GRID_W-1:0] r_grid_w;
    logic [GRID_W-1:0] r_grid_h;
    logic [LIM_W-1:0]  r_step_lim;

    logic [GRID_W-1:0] w_eff;
    logic [GRID_W-1:0] h_eff;
    logic [LIM_W-1:0]  lim_eff;

    logic [1:0]        r_step;
    t_uword            uw;
    logic              cond_ok;
    logic              br;

    t_pos              r_px;
    t_pos              r_py;
    t_dir              r_dx;
    t_dir              r_dy;
    t_cell             r_cx;
    t_cell             r_cy;
    logic              r_side;
    logic [N_W-1:0]    r_n;
    logic [DIST_W-1:0] r_dist_x;
    logic [DIST_W-1:0] r_dist_y;
    logic [SIDE_W-1:0] r_sdx;
    logic [SIDE_W-1:0] r_sdy;

    logic              r_out_valid;
    t_cell             r_out_cx;
    t_cell             r_out_cy;
    logic              r_out_side;
    logic              r_out_ing;
    t_cause            r_out_cause;
    logic              r_out_last;

    logic                div_start;
    logic                done_x;
    logic                done_y;
    logic [DELTA_W-1:0]  delta_x;
    logic [DELTA_W-1:0]  delta_y;

    t_cell             cx0;
    t_cell             cy0;
    logic              outside;
    logic [POS_FRAC_BITS-1:0] frac_x;
    logic [POS_FRAC_BITS-1:0] frac_y;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [SIDE_W-1:0] inc_x;
    logic [SIDE_W-1:0] inc_y;
    logic              out_free;
    logic              at_limit;
    logic              pick_x;
    logic [GRID_W-1:0] cx_up;
    logic [GRID_W-1:0] cy_up;
    logic              leave;
    logic              walk_last;
    logic              fire;
    logic              emit_out;
    logic              emit_walk;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w   <= GRID_W'(500);
            r_grid_h   <= GRID_W'(500);
            r_step_lim <= LIM_W'(64);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GRID_W:   r_grid_w   <= i_cfg.data;
                REG_GRID_H:   r_grid_h   <= i_cfg.data;
                REG_STEP_LIM: r_step_lim <= i_cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff   = (r_grid_w > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_grid_w;
    assign h_eff   = (r_grid_h > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_grid_h;
    assign lim_eff = (r_step_lim == '0)                ? LIM_W'(1) :
                     (r_step_lim > LIM_W'(MAX_CELLS)) ? LIM_W'(MAX_CELLS) : r_step_lim;

    // Sequencer
    assign uw       = uc_rom(r_step);
    assign out_free = !r_out_valid || o_cell.ready;

    always_comb begin
        unique case (uw.cond)
            CND_ALWAYS:   cond_ok = 1'b1;
            CND_IN_VALID: cond_ok = i_ray.valid;
            CND_OUT_FREE: cond_ok = out_free;
            CND_DIV_DONE: cond_ok = done_x && done_y;
            default:      cond_ok = 1'b0;
        endcase
    end

    assign fire        = cond_ok;
    assign i_ray.ready = (uw.act == ACT_LOAD);

    // Datapath terms
    assign cx0     = r_px[POS_W-1:POS_FRAC_BITS];
    assign cy0     = r_py[POS_W-1:POS_FRAC_BITS];
    assign outside = (GRID_W'(cx0) >= w_eff) || (GRID_W'(cy0) >= h_eff);
    assign frac_x  = r_px[POS_FRAC_BITS-1:0];
    assign frac_y  = r_py[POS_FRAC_BITS-1:0];

    assign prod_x = r_dist_x * delta_x;
    assign prod_y = r_dist_y * delta_y;
    assign inc_x  = {{(SIDE_W-DELTA_W-POS_FRAC_BITS){1'b0}}, delta_x,
                     {POS_FRAC_BITS{1'b0}}};
    assign inc_y  = {{(SIDE_W-DELTA_W-POS_FRAC_BITS){1'b0}}, delta_y,
                     {POS_FRAC_BITS{1'b0}}};

    assign at_limit  = (LIM_W'(r_n) + LIM_W'(1)) >= lim_eff;
    assign pick_x    = r_sdx < r_sdy;
    assign cx_up     = GRID_W'(r_cx) + GRID_W'(1);
    assign cy_up     = GRID_W'(r_cy) + GRID_W'(1);
    assign leave     = pick_x ? (r_dx[DIR_W-1] ? (r_cx == '0) : (cx_up >= w_eff))
                              : (r_dy[DIR_W-1] ? (r_cy == '0) : (cy_up >= h_eff));
    assign walk_last = at_limit || leave;

    assign br        = (uw.act == ACT_CHECK) ? outside : walk_last;
    assign div_start = fire && (uw.act == ACT_CHECK) && !outside;
    assign emit_out  = fire && (uw.act == ACT_CHECK) && outside;
    assign emit_walk = fire && (uw.act == ACT_WALK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else if (fire) begin
            r_step <= br ? uw.jmp : uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            unique case (uw.act)
                ACT_LOAD: begin
                    r_px <= i_ray.pos_x;
                    r_py <= i_ray.pos_y;
                    r_dx <= i_ray.dir_x;
                    r_dy <= i_ray.dir_y;
                end
                ACT_CHECK: begin
                    r_cx     <= cx0;
                    r_cy     <= cy0;
                    r_side   <= 1'b0;
                    r_n      <= '0;
                    r_dist_x <= r_dx[DIR_W-1] ? DIST_W'(frac_x)
                                              : DIST_W'(1 << POS_FRAC_BITS) - DIST_W'(frac_x);
                    r_dist_y <= r_dy[DIR_W-1] ? DIST_W'(frac_y)
                                              : DIST_W'(1 << POS_FRAC_BITS) - DIST_W'(frac_y);
                end
                ACT_SETUP: begin
                    r_sdx <= SIDE_W'(prod_x);
                    r_sdy <= SIDE_W'(prod_y);
                end
                ACT_WALK: begin
                    if (!walk_last) begin
                        r_n    <= r_n + 1'b1;
                        r_side <= !pick_x;
                        if (pick_x) begin
                            r_cx  <= r_dx[DIR_W-1] ? r_cx - 1'b1 : r_cx + 1'b1;
                            r_sdx <= r_sdx + inc_x;
                        end else begin
                            r_cy  <= r_dy[DIR_W-1] ? r_cy - 1'b1 : r_cy + 1'b1;
                            r_sdy <= r_sdy + inc_y;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    grt_recip u_recip_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dir   (r_dx),
        .o_done  (done_x),
        .o_delta (delta_x)
    );

    grt_recip u_recip_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dir   (r_dy),
        .o_done  (done_y),
        .o_delta (delta_y)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_out || emit_walk) begin
            r_out_valid <= 1'b1;
        end else if (o_cell.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_out) begin
            r_out_cx    <= cx0;
            r_out_cy    <= cy0;
            r_out_side  <= 1'b0;
            r_out_ing   <= 1'b0;
            r_out_cause <= CAUSE_START_OUT;
            r_out_last  <= 1'b1;
        end else if (emit_walk) begin
            r_out_cx    <= r_cx;
            r_out_cy    <= r_cy;
            r_out_side  <= r_side;
            r_out_ing   <= 1'b1;
            r_out_cause <= at_limit ? CAUSE_LIMIT : CAUSE_LEFT;
            r_out_last  <= walk_last;
        end
    end

    assign o_cell.valid     = r_out_valid;
    assign o_cell.cell_x    = r_out_cx;
    assign o_cell.cell_y    = r_out_cy;
    assign o_cell.hit_side  = r_out_side;
    assign o_cell.in_grid   = r_out_ing;
    assign o_cell.end_cause = r_out_cause;
    assign o_cell.last      = r_out_last;

    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ray.valid && i_ray.ready) |=> (r_step == STEP_CHECK))
        else $error("ray transfer did not start the check step");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_WALK) |-> (LIM_W'(r_n) < lim_eff))
        else $error("cell count passed the step limit");
    a_outside_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ing) |-> (r_out_last && r_out_cause == CAUSE_START_OUT))
        else $error("outside result not marked last with start-outside cause");
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_x == done_y)
        else $error("reciprocal units out of step");
endmodule

// ----- verif/grid_ray_traversal_2d_core_tb.sv -----
// Testbench for grid_ray_traversal_2d_core: drives rays, predicts the visited
// cells with a DDA walk of its own and checks every output transfer.
// Depends on grt_pkg, grt_if and the core RTL.
module grid_ray_traversal_2d_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grt_pkg::*;

    typedef struct packed {
        t_pos pos_x;
        t_pos pos_y;
        t_dir dir_x;
        t_dir dir_y;
    } t_ray_item;

    typedef struct packed {
        t_cell  cell_x;
        t_cell  cell_y;
        logic   hit_side;
        logic   in_grid;
        t_cause end_cause;
        logic   last;
    } t_cell_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    grt_ray_if  ray_ch();
    grt_cell_if cell_ch();
    grt_cfg_if  cfg_ch();

    grid_ray_traversal_2d_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch),
        .i_cfg   (cfg_ch),
        .o_cell  (cell_ch)
    );

    always #6 i_clk = ~i_clk;

    logic [9:0] grid_w = 10'd500;
    logic [9:0] grid_h = 10'd500;
    logic [6:0] step_lim = 7'd64;

    t_ray_item  pending_rays[$];
    t_cell_item due_cells[$];
    t_ray_item  held_ray;
    t_cell_item got_cell;
    t_cell_item want_cell;
    int    rays_queued = 0;
    int    rays_taken = 0;
    int    err_cnt = 0;
    int    src_gap = 0;
    int    sink_gap = 0;
    bit    quiet = 1'b0;

    function automatic t_cell_item mk_cell(input int cx, input int cy, input logic side,
                                           input logic ing, input t_cause cause,
                                           input logic lst);
        return {t_cell'(cx), t_cell'(cy), side, ing, cause, lst};
    endfunction

    function automatic void setup_axis(input t_pos p, input t_dir d, output int stp,
                                       output logic [63:0] dlt, output logic [63:0] sd);
        int          mag;
        int          frac;
        int          span;
        logic [63:0] q;
        mag = (d < 0) ? -int'(d) : int'(d);
        if (mag == 0) begin
            dlt = 64'hFFFF_FFFF;
        end else begin
            q = (64'd1 << (DIR_FRAC_BITS + DELTA_FRAC)) / mag;
            dlt = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
        end
        frac = int'(p) % (1 << POS_FRAC_BITS);
        if (d < 0) begin
            stp = -1;
            span = frac;
        end else begin
            stp = 1;
            span = (1 << POS_FRAC_BITS) - frac;
        end
        sd = 64'(span) * dlt;
    endfunction

    task automatic trace_ray(input t_ray_item r);
        int          w, h, lim, n;
        int          cx, cy, nx, ny, sx, sy;
        logic [63:0] ddx, ddy, sdx, sdy;
        logic        side, nside;
        bit          done;
        w = (int'(grid_w) > GRID_MAX) ? GRID_MAX : int'(grid_w);
        h = (int'(grid_h) > GRID_MAX) ? GRID_MAX : int'(grid_h);
        lim = int'(step_lim);
        if (lim == 0) lim = 1;
        if (lim > MAX_CELLS) lim = MAX_CELLS;
        cx = int'(r.pos_x >> POS_FRAC_BITS);
        cy = int'(r.pos_y >> POS_FRAC_BITS);
        if (cx >= w || cy >= h) begin
            due_cells.push_back(mk_cell(cx, cy, 1'b0, 1'b0, CAUSE_START_OUT, 1'b1));
            return;
        end
        setup_axis(r.pos_x, r.dir_x, sx, ddx, sdx);
        setup_axis(r.pos_y, r.dir_y, sy, ddy, sdy);
        n = 0;
        side = 1'b0;
        done = 1'b0;
        while (!done) begin
            nx = cx;
            ny = cy;
            if (n + 1 >= lim) begin
                due_cells.push_back(mk_cell(cx, cy, side, 1'b1, CAUSE_LIMIT, 1'b1));
                done = 1'b1;
            end else begin
                if (sdx < sdy) begin
                    nx += sx;
                    sdx += ddx << POS_FRAC_BITS;
                    nside = 1'b0;
                end else begin
                    ny += sy;
                    sdy += ddy << POS_FRAC_BITS;
                    nside = 1'b1;
                end
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) begin
                    due_cells.push_back(mk_cell(cx, cy, side, 1'b1, CAUSE_LEFT, 1'b1));
                    done = 1'b1;
                end else begin
                    due_cells.push_back(mk_cell(cx, cy, side, 1'b1, CAUSE_LEFT, 1'b0));
                    n++;
                    cx = nx;
                    cy = ny;
                    side = nside;
                end
            end
        end
    endtask

    function automatic t_ray_item mk_ray(input int px, input int py, input int dx,
                                         input int dy);
        t_ray_item r;
        r.pos_x = t_pos'(px);
        r.pos_y = t_pos'(py);
        r.dir_x = t_dir'(dx);
        r.dir_y = t_dir'(dy);
        return r;
    endfunction

    function automatic t_dir rand_dir();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return t_dir'(0);
            1: return ($urandom_range(0, 1) != 0) ? t_dir'(1) : t_dir'(-1);
            2: return t_dir'($urandom);
            3: return ($urandom_range(0, 1) != 0) ? t_dir'(16384) : t_dir'(-16384);
            default: return t_dir'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_ray_item rand_ray();
        int        w, h, sel;
        t_ray_item r;
        w = (int'(grid_w) > GRID_MAX) ? GRID_MAX : int'(grid_w);
        h = (int'(grid_h) > GRID_MAX) ? GRID_MAX : int'(grid_h);
        sel = $urandom_range(0, 7);
        if (sel == 0 || w == 0 || h == 0) begin
            r.pos_x = t_pos'($urandom);
            r.pos_y = t_pos'($urandom);
        end else if (sel == 1) begin
            r.pos_x = t_pos'(((w - 1) << POS_FRAC_BITS) | $urandom_range(0, 255));
            r.pos_y = t_pos'(((h - 1) << POS_FRAC_BITS) | $urandom_range(0, 255));
        end else begin
            r.pos_x = t_pos'(($urandom_range(0, w - 1) << POS_FRAC_BITS)
                             | $urandom_range(0, 255));
            r.pos_y = t_pos'(($urandom_range(0, h - 1) << POS_FRAC_BITS)
                             | $urandom_range(0, 255));
        end
        r.dir_x = rand_dir();
        r.dir_y = rand_dir();
        return r;
    endfunction

    task automatic add_ray(input t_ray_item r);
        pending_rays.push_back(r);
        rays_queued++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= t_cfg_data'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_GRID_W:   grid_w = 10'(val);
            REG_GRID_H:   grid_h = 10'(val);
            REG_STEP_LIM: step_lim = 7'(val);
            default:      ;
        endcase
    endtask

    task automatic configure(input int w, input int h, input int lim);
        write_reg(REG_GRID_W, w);
        write_reg(REG_GRID_H, h);
        write_reg(REG_STEP_LIM, lim);
    endtask

    // hold until every queued ray is taken and every predicted cell has arrived
    task automatic wait_idle();
        while (rays_taken != rays_queued || due_cells.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_ch.valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (ray_ch.valid && ray_ch.ready) begin
                trace_ray(held_ray);
                rays_taken++;
            end
            if (!ray_ch.valid || ray_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    ray_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 18);
                    ray_ch.valid <= 1'b0;
                end else if (pending_rays.size() > 0) begin
                    held_ray = pending_rays.pop_front();
                    ray_ch.valid <= 1'b1;
                    ray_ch.pos_x <= held_ray.pos_x;
                    ray_ch.pos_y <= held_ray.pos_y;
                    ray_ch.dir_x <= held_ray.dir_x;
                    ray_ch.dir_y <= held_ray.dir_y;
                end else begin
                    ray_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_ch.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (cell_ch.valid && cell_ch.ready) begin
                got_cell = {cell_ch.cell_x, cell_ch.cell_y, cell_ch.hit_side,
                            cell_ch.in_grid, cell_ch.end_cause, cell_ch.last};
                if (due_cells.size() == 0) begin
                    $display("%0t: unexpected cell transfer", $time,
                             " x=%0d y=%0d side=%0d in=%0d cause=%0d last=%0d",
                             got_cell.cell_x, got_cell.cell_y, got_cell.hit_side,
                             got_cell.in_grid, got_cell.end_cause, got_cell.last);
                    err_cnt++;
                end else begin
                    want_cell = due_cells.pop_front();
                    if (got_cell !== want_cell) begin
                        $display("%0t: cell mismatch expected", $time,
                                 " x=%0d y=%0d side=%0d in=%0d cause=%0d last=%0d",
                                 want_cell.cell_x, want_cell.cell_y, want_cell.hit_side,
                                 want_cell.in_grid, want_cell.end_cause, want_cell.last);
                        $display("%0t:                actual", $time,
                                 " x=%0d y=%0d side=%0d in=%0d cause=%0d last=%0d",
                                 got_cell.cell_x, got_cell.cell_y, got_cell.hit_side,
                                 got_cell.in_grid, got_cell.end_cause, got_cell.last);
                        err_cnt++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                cell_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 18);
                cell_ch.ready <= 1'b0;
            end else begin
                cell_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int rp_w[10]   = '{512, 37, 8, 1, 200, 1023, 0, 64, 16, 100};
        int rp_h[10]   = '{512, 23, 8, 300, 1, 1023, 5, 64, 16, 100};
        int rp_lim[10] = '{64, 64, 16, 5, 40, 127, 3, 0, 2, 64};
        int rp_cnt[10] = '{40, 40, 40, 35, 35, 40, 20, 35, 40, 60};
        ray_ch.valid = 1'b0;
        ray_ch.pos_x = '0;
        ray_ch.pos_y = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        cell_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_GRID_W;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        add_ray(mk_ray(0, 0, 16384, 0));
        add_ray(mk_ray(0, 0, 0, 0));
        add_ray(mk_ray(0, 0, -16384, -16384));
        add_ray(mk_ray(250 * 256 + 128, 250 * 256 + 128, 16384, 16384));
        add_ray(mk_ray(131071, 131071, 1, 1));
        add_ray(mk_ray(499 * 256 + 255, 10 * 256, 16384, 0));
        add_ray(mk_ray(10 * 256, 499 * 256 + 7, 0, 16384));
        add_ray(mk_ray(100 * 256, 100 * 256, -32768, 32767));
        add_ray(mk_ray(100 * 256, 100 * 256, 16385, -16385));
        add_ray(mk_ray(200 * 256 + 128, 300 * 256 + 64, 1, -1));
        add_ray(mk_ray(5 * 256, 400 * 256, -16384, 3000));
        add_ray(mk_ray(499 * 256 + 200, 499 * 256 + 100, 16384, 16384));
        add_ray(mk_ray(250 * 256, 250 * 256, 16384, 100));
        wait_idle();

        configure(512, 512, 64);
        add_ray(mk_ray(131071, 131071, 16384, 16384));
        add_ray(mk_ray(0, 0, -1, -1));
        add_ray(mk_ray(511 * 256, 0, -16384, 0));
        add_ray(mk_ray(256 * 256, 256 * 256, 12000, -9000));
        wait_idle();

        configure(1, 1, 1);
        add_ray(mk_ray(128, 128, 5000, 5000));
        add_ray(mk_ray(256, 0, 5000, 5000));
        wait_idle();

        configure(0, 1023, 0);
        add_ray(mk_ray(0, 0, 0, 0));
        wait_idle();

        configure(1023, 1023, 127);
        add_ray(mk_ray(0, 0, 16384, 16384));
        add_ray(mk_ray(131071, 131071, -16384, -16384));
        wait_idle();

        // step limit reached on the cell just before the exit
        configure(3, 3, 2);
        add_ray(mk_ray(256 + 128, 256 + 128, 16384, 0));
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            if (p == 9) quiet = 1'b1;
            configure(rp_w[p], rp_h[p], rp_lim[p]);
            for (int k = 0; k < rp_cnt[p]; k++) add_ray(rand_ray());
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && due_cells.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("%0t: timeout, %0d cells still due", $time, due_cells.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/grt_pkg.sv
rtl/core/grt_if.sv
rtl/core/grt_recip.sv
rtl/core/grid_ray_traversal_2d_core.sv
verif/grid_ray_traversal_2d_core_tb.sv
